// File: hdl/lsra_pkg.sv
// Shared constants and types for the linear scan register allocator.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package lsra_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int LSRA_MAX_REGS  = 16;
  localparam int LSRA_LINE_BITS = 16;
  localparam int LSRA_ID_BITS   = 8;

  // Fixed field widths
  localparam int FIRST_BITS     = 6;
  localparam int COUNT_BITS     = 5;
  localparam int REG_NUM_BITS   = 7;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [FIRST_BITS-1:0] FIRST_RESET = 6'd10;
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd10;

  typedef enum logic [1:0] {
    OUTCOME_GRANT = 2'd0,
    OUTCOME_EVICT = 2'd1,
    OUTCOME_SPILL = 2'd2
  } outcome_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_REG_FIRST = 4'd0,
    CFG_REG_COUNT = 4'd1
  } cfg_index_t;

endpackage

`default_nettype wire

// File: hdl/lsra_if.sv
// Valid/ready channel interfaces for the allocator: request, result, config.
// Depends on lsra_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lsra_in_if
  import lsra_pkg::*;
#(
  parameter int ID_BITS   = LSRA_ID_BITS,
  parameter int LINE_BITS = LSRA_LINE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [ID_BITS-1:0]   interval_id;
  logic [LINE_BITS-1:0] first_line;
  logic [LINE_BITS-1:0] last_line;
  logic                 new_set;

  modport source (output valid, interval_id, first_line, last_line, new_set, input ready);
  modport sink   (input valid, interval_id, first_line, last_line, new_set, output ready);
endinterface

interface lsra_out_if
  import lsra_pkg::*;
#(
  parameter int ID_BITS = LSRA_ID_BITS
);
  logic                    valid;
  logic                    ready;
  logic [ID_BITS-1:0]      result_id;
  outcome_t                outcome;
  logic [REG_NUM_BITS-1:0] reg_number;
  logic [ID_BITS-1:0]      evicted_id;

  modport source (output valid, result_id, outcome, reg_number, evicted_id, input ready);
  modport sink   (input valid, result_id, outcome, reg_number, evicted_id, output ready);
endinterface

interface lsra_cfg_if
  import lsra_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/linear_scan_register_allocator.sv
// Linear scan register allocator top level: request register, slot state,
// result register. Depends on lsra_pkg, lsra_if and lsra_pick.
`timescale 1ns / 1ps
`default_nettype none

// One live interval per request, one result per request, in order. Requests
// are expected in ascending start order, but none is checked: expiry always
// uses the present start. Each request first frees held slots
// whose end line is strictly below the new start (or all slots when new_set
// is set), then grants the lowest free slot of the pool, or else takes the
// slot of the holder with the latest end (lowest slot on a tie) when that end
// lies beyond the new end, reporting the holder as evicted; otherwise the
// request spills. The block sustains one request per clock while results are
// taken: a request is captured in an input register, resolved against all
// slots in parallel while the slot state updates, and its result is written
// into the output register once that register is free. The slot state update
// inside that single stage is what sets the rate. Write
// reg_first/reg_count only while no request is in flight; a reg_count above
// MAX_REGS behaves as MAX_REGS, and zero makes every request spill.

module linear_scan_register_allocator
  import lsra_pkg::*;
#(
  parameter int MAX_REGS  = LSRA_MAX_REGS,
  parameter int LINE_BITS = LSRA_LINE_BITS,
  parameter int ID_BITS   = LSRA_ID_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  lsra_cfg_if.sink     cfg_ch,
  lsra_in_if.sink      in_ch,
  lsra_out_if.source   out_ch
);

  localparam int SLOT_BITS = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  // Configuration registers
  logic [FIRST_BITS-1:0] reg_first_r;
  logic [COUNT_BITS-1:0] reg_count_r;

  // Input register
  logic                 in_valid_r;
  logic [ID_BITS-1:0]   in_id_r;
  logic [LINE_BITS-1:0] in_start_r;
  logic [LINE_BITS-1:0] in_end_r;
  logic                 in_new_set_r;

  // Slot state
  logic [MAX_REGS-1:0]  slot_busy_r;
  logic [MAX_REGS-1:0]  slot_busy_nxt;
  logic [LINE_BITS-1:0] slot_end_r   [MAX_REGS];
  logic [ID_BITS-1:0]   slot_owner_r [MAX_REGS];

  // Output register
  logic                    out_valid_r;
  logic [ID_BITS-1:0]      out_id_r;
  outcome_t                out_outcome_r;
  logic [REG_NUM_BITS-1:0] out_reg_r;
  logic [ID_BITS-1:0]      out_evicted_r;

  logic                    out_outcome_valid;
  outcome_t                outcome_nxt;
  logic [REG_NUM_BITS-1:0] reg_nxt;
  logic [ID_BITS-1:0]      evicted_nxt;

  // Selection results
  logic [MAX_REGS-1:0]  held;
  logic                 free_hit;
  logic [SLOT_BITS-1:0] free_slot;
  logic                 victim_hit;
  logic [SLOT_BITS-1:0] victim_slot;
  logic                 evict;
  logic                 write_en;
  logic [SLOT_BITS-1:0] write_slot;

  logic go;
  logic out_space;

  // Config writes are always taken; the user keeps them to idle periods
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_first_r <= FIRST_RESET;
      reg_count_r <= COUNT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_index_t'(cfg_ch.index))
        CFG_REG_FIRST: reg_first_r <= cfg_ch.data[FIRST_BITS-1:0];
        CFG_REG_COUNT: reg_count_r <= cfg_ch.data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: resolve the held request when the output register frees up;
  // take a new request whenever the input register empties this cycle.
  assign out_space   = !out_valid_r || out_ch.ready;
  assign go          = in_valid_r && out_space;
  assign in_ch.ready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_id_r      <= in_ch.interval_id;
      in_start_r   <= in_ch.first_line;
      in_end_r     <= in_ch.last_line;
      in_new_set_r <= in_ch.new_set;
    end
  end

  // Expire: drop holders that ended before the new start, or all on new_set
  always_comb begin
    for (int k = 0; k < MAX_REGS; k++) begin
      held[k] = slot_busy_r[k] && !in_new_set_r && !(slot_end_r[k] < in_start_r);
    end
  end

  lsra_pick #(
    .MAX_REGS  (MAX_REGS),
    .LINE_BITS (LINE_BITS),
    .SLOT_BITS (SLOT_BITS)
  ) u_pick (
    .held        (held),
    .slot_end    (slot_end_r),
    .count       (reg_count_r),
    .free_hit    (free_hit),
    .free_slot   (free_slot),
    .victim_hit  (victim_hit),
    .victim_slot (victim_slot)
  );

  // Evict only when the holder outlives the new interval; a tie spills
  assign evict      = !free_hit && victim_hit && (slot_end_r[victim_slot] > in_end_r);
  assign write_en   = free_hit || evict;
  assign write_slot = free_hit ? free_slot : victim_slot;

  always_comb begin
    slot_busy_nxt = held;
    if (free_hit)
      slot_busy_nxt[free_slot] = 1'b1;
  end

  always_comb begin
    outcome_nxt = OUTCOME_SPILL;
    reg_nxt     = '0;
    evicted_nxt = '0;
    if (free_hit) begin
      outcome_nxt = OUTCOME_GRANT;
      reg_nxt     = REG_NUM_BITS'(reg_first_r) + REG_NUM_BITS'(free_slot);
    end else if (evict) begin
      outcome_nxt = OUTCOME_EVICT;
      reg_nxt     = REG_NUM_BITS'(reg_first_r) + REG_NUM_BITS'(victim_slot);
      evicted_nxt = slot_owner_r[victim_slot];
    end
  end

  // Slot state: busy bits are control, end/owner are payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_busy_r <= '0;
    end else if (go) begin
      slot_busy_r <= slot_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && write_en) begin
      slot_end_r[write_slot]   <= in_end_r;
      slot_owner_r[write_slot] <= in_id_r;
    end
  end

  // Output register: hold until taken, advance on go
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_space) begin
      out_valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_id_r      <= in_id_r;
      out_outcome_r <= outcome_nxt;
      out_reg_r     <= reg_nxt;
      out_evicted_r <= evicted_nxt;
    end
  end

  assign out_outcome_valid = out_valid_r;

  assign out_ch.valid      = out_outcome_valid;
  assign out_ch.result_id  = out_id_r;
  assign out_ch.outcome    = out_outcome_r;
  assign out_ch.reg_number = out_reg_r;
  assign out_ch.evicted_id = out_evicted_r;

endmodule

`default_nettype wire

// File: hdl/lsra_pick.sv
// Slot selection: lowest free slot and latest-ending holder within the pool.
// Depends on lsra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsra_pick
  import lsra_pkg::*;
#(
  parameter int MAX_REGS  = LSRA_MAX_REGS,
  parameter int LINE_BITS = LSRA_LINE_BITS,
  parameter int SLOT_BITS = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
  input  logic [MAX_REGS-1:0]  held,
  input  logic [LINE_BITS-1:0] slot_end [MAX_REGS],
  input  logic [COUNT_BITS-1:0] count,
  output logic                 free_hit,
  output logic [SLOT_BITS-1:0] free_slot,
  output logic                 victim_hit,
  output logic [SLOT_BITS-1:0] victim_slot
);

  logic [MAX_REGS-1:0] in_pool;
  logic [MAX_REGS-1:0] elig;
  logic [MAX_REGS-1:0] victim_oh;

  always_comb begin
    for (int k = 0; k < MAX_REGS; k++) begin
      in_pool[k] = (k < int'(count));
      elig[k]    = in_pool[k] && held[k];
    end
  end

  // Lowest free slot: scan from the top so the lowest hit wins
  always_comb begin
    free_hit  = 1'b0;
    free_slot = '0;
    for (int k = MAX_REGS - 1; k >= 0; k--) begin
      if (in_pool[k] && !held[k]) begin
        free_hit  = 1'b1;
        free_slot = SLOT_BITS'(k);
      end
    end
  end

  // Latest end wins; on a tie the lower slot wins, so a slot must strictly
  // beat every lower eligible slot and match-or-beat every higher one.
  always_comb begin
    for (int k = 0; k < MAX_REGS; k++) begin
      victim_oh[k] = elig[k];
      for (int j = 0; j < MAX_REGS; j++) begin
        if (j < k && elig[j] && !(slot_end[k] > slot_end[j]))
          victim_oh[k] = 1'b0;
        if (j > k && elig[j] && (slot_end[k] < slot_end[j]))
          victim_oh[k] = 1'b0;
      end
    end
  end

  always_comb begin
    victim_hit  = |victim_oh;
    victim_slot = '0;
    for (int k = 0; k < MAX_REGS; k++) begin
      if (victim_oh[k])
        victim_slot = victim_slot | SLOT_BITS'(k);
    end
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_scan_register_allocator: directed corner
// intervals, then random interval streams under several pool settings.
// Depends on lsra_pkg, the lsra_if channel interfaces and the allocator RTL.

module tb_top;
  import lsra_pkg::*;

  localparam int NSLOTS      = LSRA_MAX_REGS;
  localparam int LB          = LSRA_LINE_BITS;
  localparam int IB          = LSRA_ID_BITS;
  localparam int LINE_MAX    = (1 << LB) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  // One request: a live interval as the input channel carries it
  typedef struct packed {
    logic [IB-1:0] iv_id;
    logic [LB-1:0] first_line;
    logic [LB-1:0] last_line;
    logic          fresh_set;
  } interval_t;

  // One allocation decision as the result channel carries it
  typedef struct packed {
    logic [IB-1:0]           iv_id;
    outcome_t                outcome;
    logic [REG_NUM_BITS-1:0] reg_num;
    logic [IB-1:0]           evicted;
  } grant_t;

  // Keeps its own copy of the register pool and predicts each decision at
  // the moment a request is accepted; decisions come back in request order.
  class alloc_scoreboard;
    logic [FIRST_BITS-1:0] pool_base;
    logic [COUNT_BITS-1:0] pool_size;
    bit                    slot_held [NSLOTS];
    logic [LB-1:0]         slot_last [NSLOTS];
    logic [IB-1:0]         slot_id   [NSLOTS];
    grant_t                expected_grants [$];
    int                    mismatches;
    int                    printed;

    function new();
      pool_base  = FIRST_RESET;
      pool_size  = COUNT_RESET;
      mismatches = 0;
      printed    = 0;
      for (int k = 0; k < NSLOTS; k++) begin
        slot_held[k] = 1'b0;
        slot_last[k] = '0;
        slot_id[k]   = '0;
      end
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_REG_FIRST: pool_base = data[FIRST_BITS-1:0];
        CFG_REG_COUNT: pool_size = data[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    function void note_request(interval_t iv);
      int     usable;
      int     free_k;
      int     victim;
      grant_t g;
      usable   = (pool_size > NSLOTS) ? NSLOTS : int'(pool_size);
      free_k   = -1;
      victim   = -1;
      g.iv_id   = iv.iv_id;
      g.outcome = OUTCOME_SPILL;
      g.reg_num = '0;
      g.evicted = '0;
      // Expire first: every slot, usable or not, drops a holder that ended
      // strictly before the new start, or every holder on a fresh set.
      for (int k = 0; k < NSLOTS; k++) begin
        if (iv.fresh_set || (slot_held[k] && slot_last[k] < iv.first_line))
          slot_held[k] = 1'b0;
      end
      // Lowest free slot wins; among held slots the latest end, lowest on a tie
      for (int k = 0; k < usable; k++) begin
        if (!slot_held[k]) begin
          if (free_k < 0) free_k = k;
        end else if (victim < 0 || slot_last[k] > slot_last[victim]) begin
          victim = k;
        end
      end
      if (free_k >= 0) begin
        slot_held[free_k] = 1'b1;
        slot_last[free_k] = iv.last_line;
        slot_id[free_k]   = iv.iv_id;
        g.outcome = OUTCOME_GRANT;
        g.reg_num = REG_NUM_BITS'(int'(pool_base) + free_k);
      end else if (victim >= 0 && slot_last[victim] > iv.last_line) begin
        g.evicted         = slot_id[victim];
        slot_last[victim] = iv.last_line;
        slot_id[victim]   = iv.iv_id;
        g.outcome = OUTCOME_EVICT;
        g.reg_num = REG_NUM_BITS'(int'(pool_base) + victim);
      end
      expected_grants.insert(expected_grants.size(), g);
    endfunction

    task report(string msg);
      mismatches++;
      if (printed < 40) begin
        $display("mismatch @%0t: %s", $time, msg);
        printed++;
      end
    endtask

    task check_result(grant_t got);
      grant_t want;
      if (expected_grants.size() == 0) begin
        report($sformatf("result id %0d with no request pending", got.iv_id));
        return;
      end
      want = expected_grants.pop_front();
      if (got.iv_id !== want.iv_id)
        report($sformatf("result_id %0d, want %0d", got.iv_id, want.iv_id));
      if (got.outcome !== want.outcome)
        report($sformatf("id %0d outcome %0d, want %0d", want.iv_id, got.outcome,
                         want.outcome));
      if (got.reg_num !== want.reg_num)
        report($sformatf("id %0d reg_number %0d, want %0d", want.iv_id, got.reg_num,
                         want.reg_num));
      if (got.evicted !== want.evicted)
        report($sformatf("id %0d evicted_id %0d, want %0d", want.iv_id, got.evicted,
                         want.evicted));
    endtask

    task finish_check();
      if (expected_grants.size() != 0)
        report($sformatf("%0d results never arrived", expected_grants.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  int unsigned cycles = 0;
  grant_t      seen;
  alloc_scoreboard sb;

  lsra_in_if  in_ch ();
  lsra_out_if out_ch ();
  lsra_cfg_if cfg_ch ();

  linear_scan_register_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs or drops a result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[linear_scan_register_allocator] ERROR");
      $finish;
    end
  end

  // Result side: pick ready at the falling edge; a pending hold-off forces it
  // low until the hold-off runs out so the pipeline backs up into the request side.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check every result taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.iv_id   = out_ch.result_id;
      seen.outcome = out_ch.outcome;
      seen.reg_num = out_ch.reg_number;
      seen.evicted = out_ch.evicted_id;
      sb.check_result(seen);
    end
  end

  function automatic interval_t mk_iv(int id, int first, int last, bit fresh);
    interval_t iv;
    iv.iv_id      = IB'(id);
    iv.first_line = LB'(first);
    iv.last_line  = LB'(last);
    iv.fresh_set  = fresh;
    return iv;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high into the next request unless the sender idles.
  task automatic send_request(interval_t iv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.interval_id = iv.iv_id;
    in_ch.first_line  = iv.first_line;
    in_ch.last_line   = iv.last_line;
    in_ch.new_set     = iv.fresh_set;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(iv);
    @(negedge clk);
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Drain every outstanding result, then let the pipeline settle with no request driven
  task automatic settle();
    in_ch.valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One pool setting and one random interval stream. Most requests walk the
  // start line upward with overlapping lifetimes so the pool fills, holders
  // expire and evictions happen; a few are noise, inverted or restart the set.
  task automatic run_phase(logic [7:0] first_data, logic [7:0] count_data, int items,
                           int step_max, int span_max, int hold_at);
    int        cursor;
    int        stop;
    interval_t iv;
    settle();
    write_cfg(CFG_REG_FIRST, first_data);
    write_cfg(CFG_REG_COUNT, count_data);
    cursor = $urandom_range(0, 1000);
    for (int n = 0; n < items; n++) begin
      if (n == hold_at) hold_left = HOLD_CYCLES;
      iv.iv_id     = IB'($urandom);
      iv.fresh_set = ($urandom_range(0, 99) < 3);
      if (iv.fresh_set) begin
        cursor = $urandom_range(0, LINE_MAX);
      end else begin
        cursor = cursor + $urandom_range(0, step_max);
        if (cursor > LINE_MAX) begin
          // wrap around through a fresh set so the order stays ascending
          iv.fresh_set = 1'b1;
          cursor = $urandom_range(0, 2000);
        end
      end
      stop = cursor + $urandom_range(0, span_max);
      if (stop > LINE_MAX) stop = LINE_MAX;
      iv.first_line = LB'(cursor);
      iv.last_line  = LB'(stop);
      case ($urandom_range(0, 99))
        0, 1, 2, 3, 4: begin
          // noise: arbitrary lines, order not kept
          iv.first_line = LB'($urandom);
          iv.last_line  = LB'($urandom);
        end
        5, 6, 7, 8: iv.last_line = LB'($urandom_range(0, cursor));
        default: ;
      endcase
      send_request(iv);
    end
    in_ch.valid = 1'b0;
  endtask

  initial begin
    sb = new();
    in_ch.valid       = 1'b0;
    in_ch.interval_id = '0;
    in_ch.first_line  = '0;
    in_ch.last_line   = '0;
    in_ch.new_set     = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_REG_FIRST;
    cfg_ch.data       = '0;
    send_idle_pct     = 32;
    recv_idle_pct     = 75;
    hold_left         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: two-register pool at the top of the register range so the
    // pool fills after two grants and register numbers go past 63.
    write_cfg(CFG_REG_FIRST, 8'd63);
    write_cfg(CFG_REG_COUNT, 8'd2);
    send_request(mk_iv(0, 0, 0, 1'b1));
    send_request(mk_iv(255, 0, LINE_MAX, 1'b0));
    // pool full: the holder ending at the top line is evicted
    send_request(mk_iv(1, 0, 100, 1'b0));
    // latest end equals the new end: spill
    send_request(mk_iv(2, 0, 100, 1'b0));
    send_request(mk_iv(3, 0, 50, 1'b0));
    // holder ending at line 0 expires once the start passes it
    send_request(mk_iv(4, 1, 10, 1'b0));
    // end before start; holder ending exactly at the start stays
    send_request(mk_iv(5, 10, 5, 1'b0));
    // start goes backwards: nothing expires
    send_request(mk_iv(6, 5, 7, 1'b0));
    send_request(mk_iv(8'hAA, 16'hAAAA, 16'h5555, 1'b0));
    send_request(mk_iv(8'h55, 16'h5555, 16'hAAAA, 1'b0));
    send_request(mk_iv(7, LINE_MAX, LINE_MAX, 1'b0));
    // fresh set clears the pool whatever is held
    send_request(mk_iv(8, LINE_MAX, 0, 1'b1));
    send_request(mk_iv(9, LINE_MAX, LINE_MAX, 1'b0));
    send_request(mk_iv(10, LINE_MAX, LINE_MAX, 1'b0));
    send_request(mk_iv(11, LINE_MAX, LINE_MAX, 1'b0));

    // Sender idles lightly, receiver heavily
    run_phase(8'd10, 8'd10, 250, 6, 80, -1);
    run_phase(8'd0, 8'd1, 200, 8, 30, -1);

    // Sender idles heavily, receiver lightly
    send_idle_pct = 75;
    recv_idle_pct = 32;
    run_phase(8'd63, 8'd16, 250, 3, 120, -1);
    // shrink the pool while slots from the previous phase may still be held; upper data bits set
    run_phase(8'hC5, 8'hE4, 200, 5, 40, -1);

    // No idling; long receiver hold-off partway through
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // count of 31 saturates to the full depth
    run_phase(8'hC0, 8'hFF, 250, 2, 60, 60);
    // empty pool: everything spills
    run_phase(8'd20, 8'h00, 100, 4, 50, -1);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 16)), 500, 4, 64, -1);

    settle();
    sb.finish_check();
    if (sb.mismatches == 0) begin
      $display("[linear_scan_register_allocator] OK");
    end else begin
      $display("[linear_scan_register_allocator] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lsra_pkg.sv
hdl/lsra_if.sv
hdl/lsra_pick.sv
hdl/linear_scan_register_allocator.sv
test/tb_top.sv
